### sv/tvre_pkg.sv
package tvre_pkg;

	// Field widths
	localparam int unsigned SLOT_W  = 3;
	localparam int unsigned LEVEL_W = 4;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned VEL_W   = 10;
	localparam int unsigned STOP_W  = 12;
	localparam int unsigned ACC_W   = 8;
	localparam int unsigned VSQ_W   = 2 * VEL_W;

	// Number of rows in the constant tables
	localparam int unsigned TABLE_ROWS = 5;

	// Speed level codes
	localparam logic [LEVEL_W-1:0] LEVEL_STOP = 4'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_BASE = 4'd10;
	localparam logic [LEVEL_W-1:0] LEVEL_LAST = 4'd14;

	// Divider geometry: a 32-bit dividend over a divisor of at most 12 bits
	localparam int unsigned DIVIDEND_W = 32;
	localparam int unsigned DIVISOR_W  = 12;

	// Division by 1000 and 2000 through one reciprocal: ceil(2^38 / 1000) is exact
	// for every 32-bit dividend, and one more bit of shift halves the quotient.
	localparam int unsigned RECIP_W    = 29;
	localparam logic [RECIP_W-1:0] DV_RECIP = 29'd274877907;
	localparam int unsigned DV_SHIFT   = 38;
	localparam int unsigned DIST_SHIFT = 39;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic look;
		logic mul1;
		logic div1_start;
		logic ramp;
		logic mul2;
		logic div2_start;
		logic finish;
	} tvre_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic do_update;
		logic div_done;
		logic out_free;
	} tvre_status_t;

	// Acceleration of each train row, mm/s per second
	function automatic logic [ACC_W-1:0] acc_rom(input logic [SLOT_W-1:0] row);
		logic [ACC_W-1:0] acc;
		case (row)
			3'd0:    acc = 8'd131;
			3'd1:    acc = 8'd131;
			3'd2:    acc = 8'd118;
			3'd3:    acc = 8'd180;
			3'd4:    acc = 8'd121;
			default: acc = '0;
		endcase
		return acc;
	endfunction

	// Target velocity of each train row and speed level offset, mm/s
	function automatic logic [VEL_W-1:0] target_rom(input logic [SLOT_W-1:0] row,
			input logic [2:0] idx);
		logic [VEL_W-1:0] tgt;
		case ({row, idx})
			6'o00:   tgt = 10'd327;
			6'o01:   tgt = 10'd390;
			6'o02:   tgt = 10'd455;
			6'o03:   tgt = 10'd515;
			6'o04:   tgt = 10'd595;
			6'o10:   tgt = 10'd335;
			6'o11:   tgt = 10'd397;
			6'o12:   tgt = 10'd470;
			6'o13:   tgt = 10'd530;
			6'o14:   tgt = 10'd620;
			6'o20:   tgt = 10'd303;
			6'o21:   tgt = 10'd368;
			6'o22:   tgt = 10'd438;
			6'o23:   tgt = 10'd500;
			6'o24:   tgt = 10'd600;
			6'o30:   tgt = 10'd470;
			6'o31:   tgt = 10'd535;
			6'o32:   tgt = 10'd580;
			6'o33:   tgt = 10'd620;
			6'o34:   tgt = 10'd620;
			6'o40:   tgt = 10'd265;
			6'o41:   tgt = 10'd320;
			6'o42:   tgt = 10'd370;
			6'o43:   tgt = 10'd430;
			6'o44:   tgt = 10'd495;
			default: tgt = '0;
		endcase
		return tgt;
	endfunction

endpackage

### sv/train_velocity_ramp_estimator_core.sv
// Channel  Handshake            Word fields
// in       in_valid, in_ready   train_slot, slot_active, speed_level, now_ms
// out      out_valid, out_ready velocity_mm_s, stop_distance_mm, distance_moved_mm,
//                               updated, speed_error
//
// An updating word passes through the look-up, multiply, scale, ramp, multiply and
// divider-start steps, then waits on the 8-step radix-16 divider for the stop distance.
// A word that updates nothing goes from its look-up straight to the result step.
// One word is in work at a time; in_ready is high only when idle, so a new word is
// not taken until the last one has been written to the output register.
// The result sits in an output register, so a new word is taken while it waits;
// a result still waiting holds the next one in its last step until out_ready.
// Reset clears the per-slot velocity and time stores and the control state.
module train_velocity_ramp_estimator_core
	import tvre_pkg::*;
#(
	parameter int unsigned TRAIN_SLOTS = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [SLOT_W-1:0]  train_slot,
	input  logic               slot_active,
	input  logic [LEVEL_W-1:0] speed_level,
	input  logic [TIME_W-1:0]  now_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [VEL_W-1:0]   velocity_mm_s,
	output logic [STOP_W-1:0]  stop_distance_mm,
	output logic [TIME_W-1:0]  distance_moved_mm,
	output logic               updated,
	output logic               speed_error
);

	tvre_cmd_t    cmd;
	tvre_status_t status;

	// Sequencer
	tvre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic, slot state and output register
	tvre_dpath #(
		.TRAIN_SLOTS (TRAIN_SLOTS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.train_slot        (train_slot),
		.slot_active       (slot_active),
		.speed_level       (speed_level),
		.now_ms            (now_ms),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.velocity_mm_s     (velocity_mm_s),
		.stop_distance_mm  (stop_distance_mm),
		.distance_moved_mm (distance_moved_mm),
		.updated           (updated),
		.speed_error       (speed_error)
	);

	// A rejected speed level never advances the model.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(updated && speed_error))
		else $error("word reports both an update and a speed error");

	// A word that advanced nothing carries zero results.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !updated) |->
		(velocity_mm_s == '0 && stop_distance_mm == '0 && distance_moved_mm == '0))
		else $error("non-updating word carries non-zero results");

	// Once a word is taken the block is busy on the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted again while a word is in work");

endmodule

### sv/tvre_div.sv
module tvre_div
	import tvre_pkg::*;
#(
	parameter int unsigned BITS_PER_CYCLE = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int unsigned STEPS = DIVIDEND_W / BITS_PER_CYCLE;
	localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [DIVISOR_W-1:0]  rem_d;
	logic [DIVIDEND_W-1:0] quo_d;

	// Restoring division, several quotient bits per cycle. The remainder stays
	// below the divisor, so each trial subtract is only divisor-wide.
	always_comb begin
		logic [DIVISOR_W:0]    part;
		logic [DIVIDEND_W-1:0] quo_v;
		part  = '0;
		quo_v = quo_q;
		rem_d = rem_q;
		for (int i = 0; i < BITS_PER_CYCLE; i++) begin
			part  = {rem_d, quo_v[DIVIDEND_W-1]};
			quo_v = {quo_v[DIVIDEND_W-2:0], 1'b0};
			if (part >= {1'b0, den_q}) begin
				part     = part - {1'b0, den_q};
				quo_v[0] = 1'b1;
			end
			rem_d = part[DIVISOR_W-1:0];
		end
		quo_d = quo_v;
	end

	// Control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Operand and partial result registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### sv/tvre_dpath.sv
module tvre_dpath
	import tvre_pkg::*;
#(
	parameter int unsigned TRAIN_SLOTS = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tvre_cmd_t           cmd,
	output tvre_status_t        status,
	input  logic [SLOT_W-1:0]   train_slot,
	input  logic                slot_active,
	input  logic [LEVEL_W-1:0]  speed_level,
	input  logic [TIME_W-1:0]   now_ms,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [VEL_W-1:0]    velocity_mm_s,
	output logic [STOP_W-1:0]   stop_distance_mm,
	output logic [TIME_W-1:0]   distance_moved_mm,
	output logic                updated,
	output logic                speed_error
);

	// Only slots that have a table row can hold a model
	localparam int unsigned SLOT_DEPTH = (TRAIN_SLOTS < TABLE_ROWS) ? TRAIN_SLOTS : TABLE_ROWS;
	localparam int unsigned IDX_W      = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

	// Per-slot model state
	logic [VEL_W-1:0]  vel_q  [SLOT_DEPTH];
	logic [TIME_W-1:0] time_q [SLOT_DEPTH];

	// Captured word
	logic [SLOT_W-1:0]  slot_q;
	logic               active_q;
	logic [LEVEL_W-1:0] level_q;
	logic [TIME_W-1:0]  now_q;

	// Working registers
	logic               upd_q;
	logic               bad_q;
	logic [TIME_W-1:0]  dt_q;
	logic [VEL_W-1:0]   v0_q;
	logic [ACC_W-1:0]   acc_q;
	logic [VEL_W-1:0]   tgt_q;
	logic [TIME_W-1:0]  prod_q;
	logic [TIME_W-1:0]  dv_q;
	logic [VEL_W-1:0]   v_q;
	logic [VSQ_W-1:0]   vsq_q;
	logic [TIME_W-1:0]  dprod_q;
	logic [TIME_W-1:0]  dist_q;

	// Output register
	logic               out_valid_q;
	logic [VEL_W-1:0]   out_vel_q;
	logic [STOP_W-1:0]  out_stop_q;
	logic [TIME_W-1:0]  out_dist_q;
	logic               out_upd_q;
	logic               out_err_q;

	logic                        bad_level;
	logic                        slot_ok;
	logic                        do_update;
	logic [IDX_W-1:0]            idx;
	logic [VEL_W-1:0]            gap;
	logic [VEL_W-1:0]            step;
	logic [VEL_W-1:0]            v_d;
	logic [VEL_W:0]              vsum;
	logic [TIME_W-1:0]           recip_in;
	logic [TIME_W+RECIP_W-1:0]   recip_prod;
	logic                        b_done;
	logic [DIVIDEND_W-1:0]       b_quo;

	// Classification of the captured word
	always_comb begin
		bad_level = !((level_q == LEVEL_STOP) ||
			(level_q inside {[LEVEL_BASE:LEVEL_LAST]}));
		slot_ok   = slot_q < SLOT_W'(SLOT_DEPTH);
		do_update = active_q && slot_ok && !bad_level;
		idx       = slot_q[IDX_W-1:0];
	end

	// Ramp toward the target by at most the permitted step, without overshoot
	always_comb begin
		gap  = (v0_q < tgt_q) ? (tgt_q - v0_q) : (v0_q - tgt_q);
		step = (dv_q < {{(TIME_W-VEL_W){1'b0}}, gap}) ? dv_q[VEL_W-1:0] : gap;
		if (v0_q == tgt_q) begin
			v_d = v0_q;
		end else if (v0_q < tgt_q) begin
			v_d = v0_q + step;
		end else begin
			v_d = v0_q - step;
		end
		vsum = {1'b0, v0_q} + {1'b0, v_q};
	end

	// One reciprocal multiplier divides the ramp step by 1000 and then the distance by 2000
	always_comb begin
		recip_in   = cmd.div2_start ? dprod_q : prod_q;
		recip_prod = {{RECIP_W{1'b0}}, recip_in} * {{TIME_W{1'b0}}, DV_RECIP};
	end

	// The divider serves the stop distance
	tvre_div u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div2_start),
		.dividend ({{(DIVIDEND_W-VSQ_W){1'b0}}, vsq_q}),
		.divisor  ({{(DIVISOR_W-ACC_W-1){1'b0}}, acc_q, 1'b0}),
		.done     (b_done),
		.quotient (b_quo)
	);

	// Working registers, advanced one step per command
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot_q   <= train_slot;
			active_q <= slot_active;
			level_q  <= speed_level;
			now_q    <= now_ms;
		end
		if (cmd.look) begin
			upd_q <= do_update;
			bad_q <= bad_level;
			dt_q  <= now_q - time_q[idx];
			v0_q  <= vel_q[idx];
			acc_q <= acc_rom(slot_q);
			tgt_q <= (level_q == LEVEL_STOP) ? '0 :
				target_rom(slot_q, 3'(level_q - LEVEL_BASE));
		end
		if (cmd.mul1) begin
			prod_q <= dt_q * {{(TIME_W-ACC_W){1'b0}}, acc_q};
		end
		if (cmd.div1_start) begin
			dv_q <= TIME_W'(recip_prod >> DV_SHIFT);
		end
		if (cmd.ramp) begin
			v_q <= v_d;
		end
		if (cmd.mul2) begin
			vsq_q   <= v_q * v_q;
			dprod_q <= dt_q * {{(TIME_W-VEL_W-1){1'b0}}, vsum};
		end
		if (cmd.div2_start) begin
			dist_q <= TIME_W'(recip_prod >> DIST_SHIFT);
		end
	end

	// Slot state: written back once the item's results are complete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_DEPTH; i++) begin
				vel_q[i]  <= '0;
				time_q[i] <= '0;
			end
		end else if (cmd.finish && upd_q) begin
			vel_q[idx]  <= v_q;
			time_q[idx] <= now_q;
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_vel_q  <= upd_q ? v_q : '0;
			out_stop_q <= upd_q ? b_quo[STOP_W-1:0] : '0;
			out_dist_q <= upd_q ? dist_q : '0;
			out_upd_q  <= upd_q;
			out_err_q  <= bad_q;
		end
	end

	// Status back to the controller
	always_comb begin
		status.do_update = do_update;
		status.div_done  = b_done;
		status.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid         = out_valid_q;
	assign velocity_mm_s     = out_vel_q;
	assign stop_distance_mm  = out_stop_q;
	assign distance_moved_mm = out_dist_q;
	assign updated           = out_upd_q;
	assign speed_error       = out_err_q;

endmodule

### sv/tvre_ctrl.sv
module tvre_ctrl
	import tvre_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  tvre_status_t status,
	output tvre_cmd_t    cmd
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b0_0000_0001,
		ST_LOOK   = 9'b0_0000_0010,
		ST_MUL1   = 9'b0_0000_0100,
		ST_DIV1   = 9'b0_0000_1000,
		ST_RAMP   = 9'b0_0001_0000,
		ST_MUL2   = 9'b0_0010_0000,
		ST_DIV2   = 9'b0_0100_0000,
		ST_WAIT2  = 9'b0_1000_0000,
		ST_FINISH = 9'b1_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		in_ready       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = status.do_update ? ST_MUL1 : ST_FINISH;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_DIV1;
			end
			ST_DIV1: begin
				cmd.div1_start = 1'b1;
				state_d        = ST_RAMP;
			end
			ST_RAMP: begin
				cmd.ramp = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_DIV2;
			end
			ST_DIV2: begin
				cmd.div2_start = 1'b1;
				state_d        = ST_WAIT2;
			end
			ST_WAIT2: begin
				if (status.div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### tb/tb_train_velocity_ramp_estimator_core.sv
`timescale 1ns / 100ps

module tb_train_velocity_ramp_estimator_core;
	import tvre_pkg::*;

	localparam int unsigned SLOTS = 5;
	localparam int RANDOM_WORDS = 580;
	localparam bit [31:0] DV_DIVISOR = 32'd1000;
	localparam bit [31:0] DIST_DIVISOR = 32'd2000;

	// Speed levels that the block must flag as errors.
	localparam logic [LEVEL_W-1:0] LEVEL_BAD_ONE  = 4'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_BAD_FIVE = 4'd5;
	localparam logic [LEVEL_W-1:0] LEVEL_BAD_NINE = 4'd9;
	localparam logic [LEVEL_W-1:0] LEVEL_BAD_TOP  = 4'd15;

	// Acceleration per train row and target velocity per row and level.
	localparam bit [7:0] ACCEL_MM_S2 [SLOTS] = '{8'd131, 8'd131, 8'd118, 8'd180, 8'd121};
	localparam bit [9:0] TARGET_MM_S [SLOTS][5] = '{
		'{10'd327, 10'd390, 10'd455, 10'd515, 10'd595},
		'{10'd335, 10'd397, 10'd470, 10'd530, 10'd620},
		'{10'd303, 10'd368, 10'd438, 10'd500, 10'd600},
		'{10'd470, 10'd535, 10'd580, 10'd620, 10'd620},
		'{10'd265, 10'd320, 10'd370, 10'd430, 10'd495}
	};

	typedef struct packed {
		logic [VEL_W-1:0]  velocity;
		logic [STOP_W-1:0] stop;
		logic [TIME_W-1:0] moved;
		logic              upd;
		logic              err;
	} ramp_report_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic               active;
		logic [LEVEL_W-1:0] level;
		logic [TIME_W-1:0]  now;
		logic               typed;
		ramp_report_t       want;
	} ramp_vector_t;

	localparam int DIRECTED_ROWS = 21;

	// Directed words; the result is typed in only where it is obvious.
	localparam ramp_vector_t DIRECTED [DIRECTED_ROWS] = '{
		'{3'd0, 1'b1, LEVEL_STOP,         32'h0000_0000, 1'b1, '{10'd0, 12'd0, 32'd0, 1'b1, 1'b0}},
		'{3'd0, 1'b1, LEVEL_LAST,         32'd1000,      1'b0, '0},
		'{3'd0, 1'b1, LEVEL_LAST,         32'd6000,      1'b0, '0},
		'{3'd0, 1'b1, LEVEL_LAST,         32'd6000,      1'b0, '0},
		'{3'd0, 1'b0, LEVEL_LAST,         32'd7000,      1'b1, '{10'd0, 12'd0, 32'd0, 1'b0, 1'b0}},
		'{3'd0, 1'b1, LEVEL_BAD_TOP,      32'hFFFF_FFFF, 1'b1, '{10'd0, 12'd0, 32'd0, 1'b0, 1'b1}},
		'{3'd1, 1'b1, LEVEL_BAD_ONE,      32'd500,       1'b1, '{10'd0, 12'd0, 32'd0, 1'b0, 1'b1}},
		'{3'd2, 1'b0, LEVEL_BAD_NINE,     32'd0,         1'b1, '{10'd0, 12'd0, 32'd0, 1'b0, 1'b1}},
		'{3'd5, 1'b1, LEVEL_BASE,         32'd1234,      1'b1, '{10'd0, 12'd0, 32'd0, 1'b0, 1'b0}},
		'{3'd7, 1'b1, LEVEL_BAD_TOP,      32'd99,        1'b1, '{10'd0, 12'd0, 32'd0, 1'b0, 1'b1}},
		'{3'd6, 1'b0, LEVEL_STOP,         32'hAAAA_5555, 1'b1, '{10'd0, 12'd0, 32'd0, 1'b0, 1'b0}},
		'{3'd0, 1'b1, LEVEL_STOP,         32'd8000,      1'b0, '0},
		'{3'd0, 1'b1, LEVEL_STOP,         32'd20000,     1'b0, '0},
		'{3'd1, 1'b1, LEVEL_BASE,         32'd200,       1'b0, '0},
		'{3'd1, 1'b1, LEVEL_BASE + 4'd1,  32'd3000,      1'b0, '0},
		'{3'd2, 1'b1, LEVEL_BASE + 4'd2,  32'd2500,      1'b0, '0},
		'{3'd3, 1'b1, LEVEL_BASE + 4'd3,  32'hFFFF_FFFF, 1'b0, '0},
		'{3'd3, 1'b1, LEVEL_BASE + 4'd3,  32'h0000_000F, 1'b0, '0},
		'{3'd4, 1'b1, LEVEL_LAST,         32'd4000,      1'b0, '0},
		'{3'd4, 1'b1, LEVEL_STOP,         32'h8000_0000, 1'b0, '0},
		'{3'd2, 1'b1, LEVEL_BAD_FIVE,     32'd0,         1'b1, '{10'd0, 12'd0, 32'd0, 1'b0, 1'b1}}
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [SLOT_W-1:0]  train_slot;
	logic               slot_active;
	logic [LEVEL_W-1:0] speed_level;
	logic [TIME_W-1:0]  now_ms;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [VEL_W-1:0]   velocity_mm_s;
	logic [STOP_W-1:0]  stop_distance_mm;
	logic [TIME_W-1:0]  distance_moved_mm;
	logic               updated;
	logic               speed_error;

	// Predicted per-slot state and the results still to arrive.
	bit [VEL_W-1:0]  slot_speed [SLOTS];
	bit [TIME_W-1:0] slot_time [SLOTS];
	ramp_report_t    awaited_reports [$];

	bit steady;
	int fault_count;
	int results_seen;
	int advances_seen;
	int level_faults_seen;

	train_velocity_ramp_estimator_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.train_slot        (train_slot),
		.slot_active       (slot_active),
		.speed_level       (speed_level),
		.now_ms            (now_ms),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.velocity_mm_s     (velocity_mm_s),
		.stop_distance_mm  (stop_distance_mm),
		.distance_moved_mm (distance_moved_mm),
		.updated           (updated),
		.speed_error       (speed_error)
	);

	// Clock with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Advances the predicted slot state for one word and returns its result.
	function automatic ramp_report_t ramp_estimate(input logic [SLOT_W-1:0] slot,
			input logic active, input logic [LEVEL_W-1:0] level,
			input logic [TIME_W-1:0] now);
		ramp_report_t rep;
		logic bad_level;
		bit [31:0] dt, acc, tgt, v0, v, dv, gap;
		rep = '0;
		bad_level = !(level == LEVEL_STOP || (level >= LEVEL_BASE && level <= LEVEL_LAST));
		rep.err = bad_level;
		if (active && slot < SLOTS && !bad_level) begin
			dt = now - slot_time[slot];
			acc = 32'(ACCEL_MM_S2[slot]);
			tgt = (level == LEVEL_STOP) ? 32'd0 : 32'(TARGET_MM_S[slot][level - LEVEL_BASE]);
			v0 = 32'(slot_speed[slot]);
			v = v0;
			// Ramp towards the target by the allowed step, never past it.
			if (v0 != tgt) begin
				dv = (acc * dt) / DV_DIVISOR;
				gap = (v0 < tgt) ? tgt - v0 : v0 - tgt;
				if (dv < gap)
					gap = dv;
				v = (v0 < tgt) ? v0 + gap : v0 - gap;
			end
			v = v & 32'h3FF;
			slot_time[slot] = now;
			slot_speed[slot] = v[VEL_W-1:0];
			rep.velocity = v[VEL_W-1:0];
			rep.stop = STOP_W'((v * v) / (2 * acc));
			rep.moved = ((v0 + v) * dt) / DIST_DIVISOR;
			rep.upd = 1'b1;
		end
		return rep;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d (0x%0h), got %0d (0x%0h)",
				name, want, want, got, got);
			fault_count++;
		end
	endfunction

	// Offers one word, waits for it to be taken and records the expected result.
	task automatic send_word(input logic [SLOT_W-1:0] slot, input logic active,
			input logic [LEVEL_W-1:0] level, input logic [TIME_W-1:0] now,
			input bit typed, input ramp_report_t want, output bit advanced);
		ramp_report_t rep;
		if (!steady && $urandom_range(0, 99) < 26) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < 26);
		end
		in_valid <= 1'b1;
		train_slot <= slot;
		slot_active <= active;
		speed_level <= level;
		now_ms <= now;
		do
			@(posedge clk);
		while (!in_ready);
		rep = ramp_estimate(slot, active, level, now);
		advanced = rep.upd;
		awaited_reports.push_back(typed ? want : rep);
	endtask

	// Holds the sender back until every expected result has come.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
	endtask

	// Receiver back-pressure.
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 26);
	end

	// Compare each result word with the oldest expectation.
	always @(posedge clk) begin
		ramp_report_t exp_rep;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (awaited_reports.size() == 0) begin
				$error("result word arrived with no expectation waiting");
				fault_count++;
			end else begin
				exp_rep = awaited_reports.pop_front();
				check_field("velocity_mm_s", 32'(exp_rep.velocity), 32'(velocity_mm_s));
				check_field("stop_distance_mm", 32'(exp_rep.stop), 32'(stop_distance_mm));
				check_field("distance_moved_mm", exp_rep.moved, distance_moved_mm);
				check_field("updated", 32'(exp_rep.upd), 32'(updated));
				check_field("speed_error", 32'(exp_rep.err), 32'(speed_error));
				if (exp_rep.upd)
					advances_seen++;
				if (exp_rep.err)
					level_faults_seen++;
			end
		end
	end

	// Stimulus: directed table first, then random traffic.
	initial begin
		ramp_vector_t row;
		logic [SLOT_W-1:0] slot;
		logic active;
		logic [LEVEL_W-1:0] level;
		logic [TIME_W-1:0] now;
		bit advanced;
		int updates_sent;
		int words_sent;
		int pick;
		int pick_level;
		bit [31:0] step;

		in_valid = 1'b0;
		train_slot = '0;
		slot_active = 1'b0;
		speed_level = LEVEL_STOP;
		now_ms = '0;
		arst_n = 1'b0;
		steady = 1'b0;
		updates_sent = 0;
		words_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = DIRECTED[i];
			send_word(row.slot, row.active, row.level, row.now, row.typed, row.want,
				advanced);
			words_sent++;
		end
		drain_results();

		// Mostly well-formed updates per slot with short time steps, plus noise.
		while (words_sent < DIRECTED_ROWS + RANDOM_WORDS) begin
			steady = (words_sent >= 250 && words_sent < 370);
			if (words_sent == 150)
				drain_results();
			pick = $urandom_range(0, 99);
			slot = SLOT_W'($urandom_range(0, SLOTS - 1));
			active = 1'b1;
			level = ($urandom_range(0, 99) < 15) ? LEVEL_STOP :
				LEVEL_W'(LEVEL_BASE + $urandom_range(0, 4));
			step = ($urandom_range(0, 9) == 0) ? $urandom_range(600, 6000) : $urandom_range(0, 600);
			now = slot_time[slot] + step;
			if (pick < 12) begin
				slot = SLOT_W'($urandom_range(0, 7));
				active = 1'($urandom_range(0, 1));
				level = LEVEL_W'($urandom_range(0, 15));
				now = $urandom();
			end else if (pick < 18) begin
				active = 1'b0;
			end else if (pick < 22) begin
				pick_level = $urandom_range(1, 10);
				level = (pick_level == 10) ? LEVEL_BAD_TOP : LEVEL_W'(pick_level);
			end
			send_word(slot, active, level, now, 1'b0, '0, advanced);
			words_sent++;
			if (advanced)
				updates_sent++;
		end
		steady = 1'b0;
		drain_results();
		repeat (40) @(posedge clk);

		$display("Sent %0d words (%0d directed, %0d random updates); %0d results checked.",
			words_sent, DIRECTED_ROWS, updates_sent, results_seen);
		$display("%0d results advanced a slot, %0d flagged a bad speed level.",
			advances_seen, level_faults_seen);
		if (fault_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("Timed out with %0d results outstanding.", awaited_reports.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
